### hdl/srs_pkg.sv
// Package for the sector read splitter: word types, command codes and constants.
// It also holds the small divide-by-block-size helper.
// It has no dependencies. The front end, the back end and the top level import it.
`default_nettype none

package srs_pkg;

  // Limits on one request.
  localparam int unsigned MaxRequestSectors  = 4095;
  localparam int unsigned MaxBlocksPerRead   = 127;
  localparam int unsigned MaxSectorsPerBlock = 4;
  localparam int unsigned MaxResults         = 34;
  localparam int unsigned CylLimit           = 1023;
  localparam int unsigned SectorBytes        = 512;
  localparam int unsigned SegPerSector       = SectorBytes >> 4;

  // Multiplier of 2^33/3, rounded up. It gives an exact 32-bit divide by three.
  localparam logic [31:0] RecipThree      = 32'hAAAA_AAAB;
  // Multiplier of 2^13/3, rounded up. It is exact for values below 4096.
  localparam logic [11:0] RecipThreeSmall = 12'd2731;

  // Command codes carried in each result word.
  typedef enum logic [1:0] {
    KindDirect   = 2'd0,
    KindBuffered = 2'd1,
    KindGeometry = 2'd2,
    KindRangeErr = 2'd3
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgBlockMode = 2'd0,
    CfgSpb       = 2'd1,
    CfgSpt       = 2'd2,
    CfgSpc       = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FrIdle,
    FrBlock,
    FrDivCyl,
    FrDivHead,
    FrSend
  } fr_state_e;

  typedef enum logic {
    BkIdle,
    BkRun
  } bk_state_e;

  // Request word.
  typedef struct packed {
    logic [31:0] start_sector;
    logic [11:0] sector_count;
    logic [15:0] buffer_segment;
  } req_t;

  // Result word.
  typedef struct packed {
    kind_e       command_kind;
    logic [31:0] block_number;
    logic [6:0]  block_count;
    logic [1:0]  copy_offset;
    logic [11:0] run_sectors;
    logic [15:0] dest_segment;
    logic [7:0]  cylinder_low;
    logic [7:0]  sector_field;
    logic [7:0]  head_number;
    logic [11:0] sectors_done;
    logic        last_command;
  } res_t;

  // Configuration as seen by the front end.
  typedef struct packed {
    logic        block_mode;
    logic [2:0]  spb;
    logic [5:0]  spt;
    logic [13:0] spc;
  } cfg_t;

  // Classified job passed from the front end to the back end.
  typedef struct packed {
    logic        geo;
    kind_e       kind;
    logic [31:0] start;
    logic [31:0] blk;
    logic [1:0]  off;
    logic [2:0]  spb;
    logic [11:0] whole;
    logic [1:0]  crem;
    logic [11:0] count;
    logic [15:0] seg;
    logic [7:0]  cyl_low;
    logic [7:0]  sec_field;
    logic [7:0]  head;
  } job_t;

  typedef struct packed {
    logic [11:0] q;
    logic [1:0]  r;
  } small_div_t;

  // Quotient and remainder of a 12-bit value by a block size of 1 to 4.
  function automatic small_div_t div_spb(input logic [11:0] x, input logic [2:0] spb);
    small_div_t  res;
    logic [23:0] prod;
    logic [11:0] back;
    prod = 24'(x) * 24'(RecipThreeSmall);
    back = 12'(prod[23:13] * 11'd3);
    case (spb)
      3'd2: begin
        res.q = x >> 1;
        res.r = {1'b0, x[0]};
      end
      3'd3: begin
        res.q = {1'b0, prod[23:13]};
        res.r = 2'(x - back);
      end
      3'd4: begin
        res.q = x >> 2;
        res.r = x[1:0];
      end
      default: begin
        res.q = x;
        res.r = 2'd0;
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/srs_fifo.sv
// Small register-based queue. It carries jobs between the front and the back,
// and it holds result words for the consumer. It depends on nothing. Depth must be at least 2.
`default_nettype none

module srs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage: payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/srs_front.sv
// Front end of the sector read splitter. It accepts request words and classifies
// them. It works out the block position or the geometry. Depends on srs_pkg.
`default_nettype none

module srs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  srs_pkg::req_t req_i,
  output logic          full_o,
  input  srs_pkg::cfg_t cfg_i,
  output logic          job_push_o,
  output srs_pkg::job_t job_o,
  input  logic          job_full_i
);

  import srs_pkg::*;

  fr_state_e   state_q, state_d;
  req_t        req_q, req_d;
  logic [2:0]  spb_q, spb_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] quo_q, quo_d;
  logic [13:0] rem_q, rem_d;
  logic [13:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [9:0]  cyl_q, cyl_d;
  logic        cyl_over_q, cyl_over_d;
  job_t        job_q, job_d;

  logic [14:0] shl;
  logic        ge;
  logic [13:0] rem_nx;
  logic [31:0] quo_nx;
  logic [2:0]  spb_in;
  logic [5:0]  spt_eff;
  logic [13:0] spc_eff;
  logic [11:0] count_in;
  logic [31:0] blk;
  logic [1:0]  off;
  small_div_t  wdiv;
  logic [6:0]  sec1;

  assign full_o     = (state_q != FrIdle);
  assign job_push_o = (state_q == FrSend);
  assign job_o      = job_q;

  // Clamp the configuration and the count to their working ranges.
  always_comb begin
    if (cfg_i.spb == 3'd0) begin
      spb_in = 3'd1;
    end else if (32'(cfg_i.spb) > MaxSectorsPerBlock) begin
      spb_in = 3'(MaxSectorsPerBlock);
    end else begin
      spb_in = cfg_i.spb;
    end
    spt_eff  = (cfg_i.spt == 6'd0) ? 6'd1 : cfg_i.spt;
    spc_eff  = (cfg_i.spc == 14'd0) ? 14'd1 : cfg_i.spc;
    count_in = (32'(req_i.sector_count) > MaxRequestSectors) ?
               12'(MaxRequestSectors) : req_i.sector_count;
  end

  // One restoring divide step: one quotient bit per cycle.
  always_comb begin
    shl    = {rem_q, quo_q[31]};
    ge     = (shl >= {1'b0, dvs_q});
    rem_nx = ge ? 14'(shl - {1'b0, dvs_q}) : shl[13:0];
    quo_nx = {quo_q[30:0], ge};
  end

  // Block position of the start sector, for block mode.
  always_comb begin
    case (spb_q)
      3'd2: begin
        blk = req_q.start_sector >> 1;
        off = {1'b0, req_q.start_sector[0]};
      end
      3'd3: begin
        blk = {1'b0, prod_q[63:33]};
        off = req_q.start_sector[1:0] - 2'(blk[1:0] * 2'd3);
      end
      3'd4: begin
        blk = req_q.start_sector >> 2;
        off = req_q.start_sector[1:0];
      end
      default: begin
        blk = req_q.start_sector;
        off = 2'd0;
      end
    endcase
    wdiv = div_spb(req_q.sector_count, spb_q);
    sec1 = {1'b0, rem_nx[5:0]} + 7'd1;
  end

  // Sequencer: next state and datapath loads.
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    spb_d      = spb_q;
    prod_d     = prod_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    dvs_d      = dvs_q;
    cnt_d      = cnt_q;
    cyl_d      = cyl_q;
    cyl_over_d = cyl_over_q;
    job_d      = job_q;
    case (state_q)
      FrIdle: begin
        req_d              = req_i;
        req_d.sector_count = count_in;
        spb_d              = spb_in;
        prod_d             = {32'd0, req_i.start_sector} * {32'd0, RecipThree};
        quo_d              = req_i.start_sector;
        rem_d              = '0;
        dvs_d              = spc_eff;
        cnt_d              = 5'd31;
        if (push_i && (count_in != 12'd0)) begin
          state_d = cfg_i.block_mode ? FrBlock : FrDivCyl;
        end
      end
      FrBlock: begin
        job_d.geo       = 1'b0;
        job_d.kind      = KindDirect;
        job_d.start     = req_q.start_sector;
        job_d.blk       = blk;
        job_d.off       = off;
        job_d.spb       = spb_q;
        job_d.whole     = wdiv.q;
        job_d.crem      = wdiv.r;
        job_d.count     = req_q.sector_count;
        job_d.seg       = req_q.buffer_segment;
        job_d.cyl_low   = '0;
        job_d.sec_field = '0;
        job_d.head      = '0;
        state_d         = FrSend;
      end
      FrDivCyl: begin
        quo_d = quo_nx;
        rem_d = rem_nx;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          // Cylinder done; divide the remainder by the track length next.
          cyl_d      = quo_nx[9:0];
          cyl_over_d = (quo_nx > 32'(CylLimit));
          quo_d      = {rem_nx, 18'd0};
          rem_d      = '0;
          dvs_d      = {8'd0, spt_eff};
          cnt_d      = 5'd13;
          state_d    = FrDivHead;
        end
      end
      FrDivHead: begin
        quo_d = quo_nx;
        rem_d = rem_nx;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          job_d.geo   = 1'b1;
          job_d.start = req_q.start_sector;
          job_d.blk   = '0;
          job_d.off   = '0;
          job_d.spb   = spb_q;
          job_d.whole = '0;
          job_d.crem  = '0;
          job_d.count = req_q.sector_count;
          job_d.seg   = req_q.buffer_segment;
          if (cyl_over_q) begin
            job_d.kind      = KindRangeErr;
            job_d.cyl_low   = '0;
            job_d.sec_field = '0;
            job_d.head      = '0;
          end else begin
            job_d.kind      = KindGeometry;
            job_d.cyl_low   = cyl_q[7:0];
            job_d.sec_field = 8'(sec1) + {cyl_q[9:8], 6'd0};
            job_d.head      = quo_nx[7:0];
          end
          state_d = FrSend;
        end
      end
      FrSend: begin
        if (!job_full_i) begin
          state_d = FrIdle;
        end
      end
      default: begin
        state_d = FrIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers: payload only, no reset.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    spb_q      <= spb_d;
    prod_q     <= prod_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    cnt_q      <= cnt_d;
    cyl_q      <= cyl_d;
    cyl_over_q <= cyl_over_d;
    job_q      <= job_d;
  end

endmodule

`default_nettype wire

### hdl/srs_back.sv
// Back end of the sector read splitter. Depends on srs_pkg. It takes classified
// jobs and emits one command per cycle unless stalled, until served or 34 sent.
`default_nettype none

module srs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  srs_pkg::job_t job_i,
  input  logic          job_empty_i,
  output logic          job_pop_o,
  output srs_pkg::res_t res_o,
  output logic          res_push_o,
  input  logic          res_full_i
);

  import srs_pkg::*;

  bk_state_e   state_q, state_d;
  logic        geo_q;
  kind_e       kind_q;
  logic [31:0] start_q, blk_q;
  logic [1:0]  off_q, crem_q;
  logic [2:0]  spb_q;
  logic [11:0] whole_q, count_q, done_q;
  logic [15:0] seg_q;
  logic [5:0]  n_q;
  logic [7:0]  cyl_q, secf_q, head_q;

  logic [6:0]  w;
  logic        direct;
  logic [2:0]  span;
  logic [11:0] run_dir, run_buf, run;
  logic [11:0] count_nx, done_nx;
  logic        last;
  logic [32:0] start_sum;
  small_div_t  wrap_div;
  logic [5:0]  n_nx;
  logic        step;

  assign job_pop_o  = (state_q == BkIdle) && !job_empty_i;
  assign res_push_o = (state_q == BkRun) && !res_full_i;
  assign step       = res_push_o;

  // Size of the next run in either mode, and the totals after it.
  always_comb begin
    w       = (whole_q > 12'(MaxBlocksPerRead)) ? 7'(MaxBlocksPerRead) : whole_q[6:0];
    direct  = (off_q == 2'd0) && (whole_q != 12'd0);
    span    = spb_q - {1'b0, off_q};
    run_dir = 12'(w) * 12'(spb_q);
    run_buf = (count_q < 12'(span)) ? count_q : 12'(span);
    if (geo_q) begin
      run = (kind_q == KindRangeErr) ? 12'd0 : count_q;
    end else begin
      run = direct ? run_dir : run_buf;
    end
    count_nx  = count_q - run;
    done_nx   = done_q + run;
    last      = geo_q || (count_nx == 12'd0);
    start_sum = {1'b0, start_q} + 33'(run);
    wrap_div  = div_spb(start_sum[11:0], spb_q);
    n_nx      = n_q + 6'd1;
  end

  // Result word for the current command.
  always_comb begin
    res_o.dest_segment = seg_q;
    res_o.run_sectors  = run;
    res_o.sectors_done = done_nx;
    res_o.last_command = last;
    if (geo_q) begin
      res_o.command_kind = kind_q;
      res_o.block_number = '0;
      res_o.block_count  = '0;
      res_o.copy_offset  = '0;
      res_o.cylinder_low = cyl_q;
      res_o.sector_field = secf_q;
      res_o.head_number  = head_q;
    end else begin
      res_o.command_kind = direct ? KindDirect : KindBuffered;
      res_o.block_number = blk_q;
      res_o.block_count  = direct ? w : 7'd1;
      res_o.copy_offset  = direct ? 2'd0 : off_q;
      res_o.cylinder_low = '0;
      res_o.sector_field = '0;
      res_o.head_number  = '0;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (!job_empty_i) begin
          state_d = BkRun;
        end
      end
      BkRun: begin
        if (step && (last || (n_nx == 6'(MaxResults)))) begin
          state_d = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Run state: loaded from a job, then advanced after each command.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      geo_q   <= job_i.geo;
      kind_q  <= job_i.kind;
      start_q <= job_i.start;
      blk_q   <= job_i.blk;
      off_q   <= job_i.off;
      spb_q   <= job_i.spb;
      whole_q <= job_i.whole;
      crem_q  <= job_i.crem;
      count_q <= job_i.count;
      seg_q   <= job_i.seg;
      cyl_q   <= job_i.cyl_low;
      secf_q  <= job_i.sec_field;
      head_q  <= job_i.head;
      done_q  <= '0;
      n_q     <= '0;
    end else if (step) begin
      count_q <= count_nx;
      done_q  <= done_nx;
      n_q     <= n_nx;
      seg_q   <= seg_q + 16'(32'(run) * SegPerSector);
      start_q <= start_sum[31:0];
      // After a wrap of the sector address, the block position is found again.
      if (start_sum[32]) begin
        blk_q <= {20'd0, wrap_div.q};
        off_q <= wrap_div.r;
      end else begin
        blk_q <= blk_q + (direct ? {25'd0, w} : 32'd1);
        off_q <= 2'd0;
      end
      // Keep whole blocks and leftover sectors of the remaining count.
      if (direct) begin
        whole_q <= whole_q - 12'(w);
      end else if ({1'b0, crem_q} >= span) begin
        crem_q <= 2'({1'b0, crem_q} - span);
      end else begin
        crem_q  <= 2'({1'b0, crem_q} + spb_q - span);
        whole_q <= whole_q - 12'd1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/sector_read_splitter_unit.sv
// Top level of the sector read splitter. It holds the configuration registers,
// the front end, the job queue, the back end and the result queue.
// Depends on srs_pkg, srs_fifo, srs_front and srs_back.
//
//   Channel   Direction  Handshake              Word
//   request   in         push / full            req_i   (srs_pkg::req_t)
//   result    out        empty / pop            res_o   (srs_pkg::res_t)
//   config    in/out     psel/penable/pready    paddr, pwdata, prdata
//
// Block mode: the front end goes through its block and send states; the back end then
// emits one command per cycle while the result queue has room, up to 34 for one request,
// and passes through its idle state between jobs. Geometry mode: the front end runs the
// serial divider, 32 steps for the cylinder and 14 for the head, then hands over the job.
// Reset clears the sequencers and the queues and sets the configuration registers to defaults.
// A full result queue stalls the back end; the front end fills the job queue, then holds full.
`default_nettype none

module sector_read_splitter_unit #(
  parameter int unsigned JobDepth = 2,
  parameter int unsigned ResDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  srs_pkg::req_t req_i,
  output logic          empty,
  input  logic          pop,
  output srs_pkg::res_t res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  import srs_pkg::*;

  localparam int unsigned JobW = $bits(job_t);
  localparam int unsigned ResW = $bits(res_t);

  cfg_t     cfg_q;
  cfg_idx_e cfg_idx;
  logic     cfg_wr;
  job_t     job_in, job_out;
  logic     job_push, job_full, job_pop, job_empty;
  res_t     res_in;
  logic     res_push, res_full;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_mode <= 1'b0;
      cfg_q.spb        <= 3'd1;
      cfg_q.spt        <= 6'd63;
      cfg_q.spc        <= 14'd16065;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CfgBlockMode: cfg_q.block_mode <= pwdata[0];
        CfgSpb:       cfg_q.spb        <= pwdata[2:0];
        CfgSpt:       cfg_q.spt        <= pwdata[5:0];
        CfgSpc:       cfg_q.spc        <= pwdata[13:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      CfgBlockMode: prdata = {31'd0, cfg_q.block_mode};
      CfgSpb:       prdata = {29'd0, cfg_q.spb};
      CfgSpt:       prdata = {26'd0, cfg_q.spt};
      CfgSpc:       prdata = {18'd0, cfg_q.spc};
      default:      prdata = '0;
    endcase
  end

  // Front end: accepts and classifies requests.
  srs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .req_i      (req_i),
    .full_o     (full),
    .cfg_i      (cfg_q),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  // Queue of classified jobs.
  srs_fifo #(
    .Width (JobW),
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // Back end: emits the commands of each job.
  srs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Result queue facing the consumer.
  srs_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_o),
    .empty_o (empty)
  );

  // The back end never pushes into a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(res_push && res_full))
    else $error("result written into a full queue");

  // A job is only taken when one is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(job_pop && job_empty))
    else $error("job taken from an empty queue");

  // The running total covers at least the sectors of the current command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (res_o.command_kind != KindRangeErr)) |->
      (res_o.sectors_done >= res_o.run_sectors))
    else $error("running total below run length");

  // A buffered read is one block and delivers at least one sector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (res_o.command_kind == KindBuffered)) |->
      ((res_o.block_count == 7'd1) && (res_o.run_sectors != 12'd0)))
    else $error("malformed buffered read");

endmodule

`default_nettype wire

### verif/srs_checker.sv
// Checker for the sector read splitter: watches the request, result and configuration
// channels, works out the command words that each request should give and compares them.
// Depends on srs_pkg for the word types, command codes and limits.
module srs_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          full_i,
  input  srs_pkg::req_t req_i,
  input  logic          empty_i,
  input  logic          pop_i,
  input  srs_pkg::res_t res_i,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic          pready_i,
  input  logic [3:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output int unsigned   mismatches_o,
  output int unsigned   cmds_waiting_o
);

  import srs_pkg::*;

  localparam int unsigned PrintCap = 100;

  // Local copy of the configuration registers.
  logic        block_mode_q;
  logic [2:0]  spb_q;
  logic [5:0]  spt_q;
  logic [13:0] spc_q;

  res_t        expected_cmds[$];
  res_t        want_cmd;
  int unsigned mismatch_total = 0;
  int unsigned cmds_seen = 0;

  assign mismatches_o = mismatch_total;

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string msg);
    if (mismatch_total < PrintCap) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatch_total++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("command %0d: %s is %0h, expected %0h",
                                cmds_seen, name, got, want));
    end
  endtask

  task automatic compare_cmd(input res_t got, input res_t want);
    check_field("command_kind", got.command_kind, want.command_kind);
    check_field("block_number", got.block_number, want.block_number);
    check_field("block_count", got.block_count, want.block_count);
    check_field("copy_offset", got.copy_offset, want.copy_offset);
    check_field("run_sectors", got.run_sectors, want.run_sectors);
    check_field("dest_segment", got.dest_segment, want.dest_segment);
    check_field("cylinder_low", got.cylinder_low, want.cylinder_low);
    check_field("sector_field", got.sector_field, want.sector_field);
    check_field("head_number", got.head_number, want.head_number);
    check_field("sectors_done", got.sectors_done, want.sectors_done);
    check_field("last_command", got.last_command, want.last_command);
  endtask

  // Works out the run of command words for one request under the current settings.
  // The 12-bit count can never exceed the request limit, so no saturation is needed.
  task automatic expand_request(input req_t rq);
    logic [31:0] start;
    logic [11:0] left;
    logic [11:0] done;
    logic [15:0] seg;
    logic [31:0] spc;
    logic [31:0] spt;
    logic [31:0] cyl;
    logic [31:0] rem;
    logic [31:0] head;
    logic [31:0] sec;
    int unsigned spb;
    int unsigned off;
    int unsigned whole;
    int unsigned run;
    int unsigned n;
    res_t        cmd;
    start = rq.start_sector;
    left  = rq.sector_count;
    seg   = rq.buffer_segment;
    done  = '0;
    n     = 0;
    if (left == 0) return;
    if (block_mode_q) begin
      // A block size of zero acts as one; anything above the maximum is clamped.
      spb = (spb_q == 0) ? 1 : (spb_q > MaxSectorsPerBlock) ? MaxSectorsPerBlock : spb_q;
      while (left != 0 && n < MaxResults) begin
        cmd   = '0;
        off   = start % spb;
        whole = left / spb;
        cmd.block_number = start / spb;
        if (off == 0 && whole > 0) begin
          // Aligned run of whole blocks goes straight to the destination.
          if (whole > MaxBlocksPerRead) whole = MaxBlocksPerRead;
          run = whole * spb;
          cmd.command_kind = KindDirect;
          cmd.block_count  = 7'(whole);
        end else begin
          // Partial block: read into the local buffer and copy part of it.
          run = spb - off;
          if (run > left) run = left;
          cmd.command_kind = KindBuffered;
          cmd.block_count  = 7'd1;
          cmd.copy_offset  = 2'(off);
        end
        done = done + 12'(run);
        left = left - 12'(run);
        cmd.run_sectors  = 12'(run);
        cmd.dest_segment = seg;
        cmd.sectors_done = done;
        cmd.last_command = (left == 0);
        expected_cmds.push_back(cmd);
        n++;
        start = start + 32'(run);
        seg   = seg + 16'(run * SegPerSector);
      end
    end else begin
      // Geometry mode gives a single command for the whole request.
      spc  = (spc_q == 0) ? 32'd1 : 32'(spc_q);
      spt  = (spt_q == 0) ? 32'd1 : 32'(spt_q);
      cyl  = start / spc;
      rem  = start % spc;
      head = rem / spt;
      sec  = rem % spt + 32'd1;
      cmd  = '0;
      cmd.dest_segment = seg;
      cmd.last_command = 1'b1;
      if (cyl > CylLimit) begin
        cmd.command_kind = KindRangeErr;
      end else begin
        cmd.command_kind = KindGeometry;
        cmd.run_sectors  = left;
        cmd.cylinder_low = cyl[7:0];
        cmd.sector_field = 8'(sec + ((cyl & 32'h300) >> 2));
        cmd.head_number  = head[7:0];
        cmd.sectors_done = left;
      end
      expected_cmds.push_back(cmd);
    end
  endtask

  // Results are checked before the request of the same edge is expanded, since a
  // request cannot produce a word in the cycle it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_mode_q   <= 1'b0;
      spb_q          <= 3'd1;
      spt_q          <= 6'd63;
      spc_q          <= 14'd16065;
      cmds_waiting_o <= 0;
      expected_cmds.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("command %0d arrived with nothing expected", cmds_seen));
        end else begin
          want_cmd = expected_cmds.pop_front();
          compare_cmd(res_i, want_cmd);
        end
        cmds_seen++;
      end
      if (push_i && !full_i) begin
        expand_request(req_i);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (cfg_idx_e'(paddr_i[3:2]))
          CfgBlockMode: block_mode_q <= pwdata_i[0];
          CfgSpb:       spb_q        <= pwdata_i[2:0];
          CfgSpt:       spt_q        <= pwdata_i[5:0];
          CfgSpc:       spc_q        <= pwdata_i[13:0];
          default: ;
        endcase
      end
      cmds_waiting_o <= expected_cmds.size();
    end
  end

endmodule

### verif/sector_read_splitter_unit_tb.sv
// Testbench top for the sector read splitter: drives requests, result pops and
// register writes, and gives the verdict from the checker's mismatch count.
// Depends on srs_pkg, sector_read_splitter_unit and srs_checker.
module sector_read_splitter_unit_tb;
  import srs_pkg::*;

  localparam int unsigned SettleCycles  = 300;
  localparam int unsigned RandomPhases  = 10;
  localparam int unsigned ItemsPerPhase = 40;
  localparam int unsigned PressurePhase = 2;
  localparam int unsigned PressureHold  = 600;
  localparam int unsigned TimeLimit     = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  req_t        req_i;
  logic        empty;
  logic        pop;
  res_t        res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned mismatches;
  int unsigned cmds_waiting;

  bit          rx_idle_on  = 1'b1;
  bit          tx_gaps_on  = 1'b1;
  int unsigned rx_hold_len = 0;

  always #2 clk_i = ~clk_i;

  sector_read_splitter_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .req_i   (req_i),
    .empty   (empty),
    .pop     (pop),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  srs_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .req_i          (req_i),
    .empty_i        (empty),
    .pop_i          (pop),
    .res_i          (res_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .mismatches_o   (mismatches),
    .cmds_waiting_o (cmds_waiting)
  );

  // Register write: setup cycle, then access cycle until pready is seen.
  task automatic apb_write(input cfg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic mode, input logic [2:0] spb,
                            input logic [5:0] spt, input logic [13:0] spc);
    apb_write(CfgBlockMode, {31'd0, mode});
    apb_write(CfgSpb, {29'd0, spb});
    apb_write(CfgSpt, {26'd0, spt});
    apb_write(CfgSpc, {18'd0, spc});
  endtask

  // Offers one request word, with an optional gap first, and returns once it is taken.
  task automatic send_request(input logic [31:0] start, input logic [11:0] count,
                              input logic [15:0] seg);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= '{start_sector: start, sector_count: count, buffer_segment: seg};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Stops offering, waits for every expected word, then lets any request that
  // gives no word work its way through the front end.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (cmds_waiting != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random request shaped for the current settings: most starts give a valid
  // cylinder in geometry mode, and about half are block-aligned in block mode.
  function automatic req_t random_request(input logic mode, input logic [2:0] spb,
                                          input logic [13:0] spc, input bit heavy);
    req_t        rq;
    int unsigned pick;
    int unsigned blk;
    int unsigned spc_eff;
    blk     = (spb == 0) ? 1 : (spb > MaxSectorsPerBlock) ? MaxSectorsPerBlock : spb;
    spc_eff = (spc == 0) ? 1 : spc;
    pick = $urandom_range(0, 15);
    if (heavy) rq.sector_count = 12'($urandom_range(500, 4095));
    else if (pick == 0) rq.sector_count = 12'd0;
    else if (pick < 10) rq.sector_count = 12'($urandom_range(1, 16));
    else if (pick < 13) rq.sector_count = 12'($urandom_range(17, 600));
    else rq.sector_count = 12'($urandom_range(601, 4095));
    pick = $urandom_range(0, 7);
    if (pick == 0) rq.start_sector = $urandom;
    else if (pick == 1) rq.start_sector = 32'hFFFF_FFFF - $urandom_range(0, 600);
    else if (!mode) rq.start_sector = $urandom_range(0, spc_eff * 1024 + 64);
    else rq.start_sector = $urandom_range(0, 32'h000F_FFFF);
    if (mode && $urandom_range(0, 1) == 1) begin
      rq.start_sector = rq.start_sector - (rq.start_sector % blk);
    end
    rq.buffer_segment = 16'($urandom_range(0, 65535));
    return rq;
  endfunction

  // Result side: pops with random stalls, and honours a long hold when asked.
  initial begin : result_drain
    int unsigned hold;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_len != 0) begin
        hold = rx_hold_len;
        rx_hold_len = 0;
        pop <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    #(TimeLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic        mode;
    logic [2:0]  spb;
    logic [5:0]  spt;
    logic [13:0] spc;
    bit          heavy;
    req_t        rq;
    rst_ni  <= 1'b0;
    push    <= 1'b0;
    req_i   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Geometry mode at the usual disk geometry: edges of the cylinder range,
    // the range error, an empty request and the high cylinder bits.
    set_config(1'b0, 3'd1, 6'd63, 14'd16065);
    send_request(32'd0, 12'd1, 16'h0000);
    send_request(32'd16450559, 12'd4095, 16'hFFFF);
    send_request(32'd16450560, 12'd7, 16'h1234);
    send_request(32'hFFFF_FFFF, 12'd1, 16'h0000);
    send_request(32'd100, 12'd0, 16'h0000);
    send_request(32'd16065 * 769 + 63 * 5 + 7, 12'd12, 16'hABCD);
    // One sector per track makes the head index overflow eight bits.
    wait_idle();
    set_config(1'b0, 3'd1, 6'd1, 14'd16065);
    send_request(32'd16064, 12'd3, 16'h0100);
    // Zero geometry acts as one sector per track and per cylinder.
    wait_idle();
    set_config(1'b0, 3'd1, 6'd0, 14'd0);
    send_request(32'd1023, 12'd5, 16'h0200);
    send_request(32'd1024, 12'd5, 16'h0000);

    // Block mode: longest requests, segment and sector address wrap, partial blocks.
    wait_idle();
    set_config(1'b1, 3'd1, 6'd63, 14'd16065);
    send_request(32'd0, 12'd4095, 16'hFFF0);
    send_request(32'hFFFF_FFFE, 12'd300, 16'h0000);
    wait_idle();
    set_config(1'b1, 3'd4, 6'd63, 14'd16383);
    send_request(32'd5, 12'd4095, 16'h8000);
    send_request(32'd8, 12'd3, 16'h0000);
    send_request(32'd7, 12'd1, 16'h0010);
    send_request(32'hFFFF_FFFD, 12'd10, 16'h0000);
    wait_idle();
    set_config(1'b1, 3'd3, 6'd63, 14'd16065);
    send_request(32'd1, 12'd4095, 16'h0000);
    send_request(32'd3, 12'd8, 16'hFFFF);
    send_request(32'd0, 12'd0, 16'h0000);
    // Block size of zero acts as one, and one above the maximum acts as four.
    wait_idle();
    set_config(1'b1, 3'd0, 6'd63, 14'd16065);
    send_request(32'd12345, 12'd200, 16'h4321);
    wait_idle();
    set_config(1'b1, 3'd7, 6'd63, 14'd16065);
    send_request(32'd2, 12'd9, 16'h0001);
    wait_idle();
    set_config(1'b1, 3'd2, 6'd63, 14'd16065);
    send_request(32'd1, 12'd4095, 16'h7777);
    send_request(32'h8000_0000, 12'd2, 16'h0000);

    // Random phases, each under fresh settings. One phase holds the result side
    // off for a long stretch with heavy block-mode requests so that the block
    // backs up; the last phases run with no idling at all.
    for (int p = 0; p < RandomPhases; p++) begin
      wait_idle();
      heavy = (p == PressurePhase);
      if (p >= RandomPhases - 2) begin
        rx_idle_on = 1'b0;
        tx_gaps_on = 1'b0;
      end
      mode = heavy ? 1'b1 : 1'($urandom_range(0, 1));
      spb  = heavy ? 3'd1 : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0: spt = 6'd0;
        1: spt = 6'd1;
        2: spt = 6'd63;
        default: spt = 6'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 6))
        0: spc = 14'd0;
        1: spc = 14'd1;
        2: spc = 14'd16065;
        3: spc = 14'd16383;
        default: spc = 14'($urandom_range(0, 16383));
      endcase
      set_config(mode, spb, spt, spc);
      if (heavy) begin
        tx_gaps_on  = 1'b0;
        rx_hold_len = PressureHold;
      end
      for (int i = 0; i < ItemsPerPhase; i++) begin
        rq = random_request(mode, spb, spc, heavy);
        send_request(rq.start_sector, rq.sector_count, rq.buffer_segment);
      end
      if (heavy) tx_gaps_on = 1'b1;
    end
    wait_idle();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
